FILE: src/skt_pkg.sv
package skt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

	// field widths
	localparam int KEY_W  = 32;
	localparam int NAME_W = 64;
	localparam int QTY_W  = 32;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;
	localparam logic [1:0] ACT_DUMP   = 2'd3;

	// result status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_NOT_FOUND = 3'd1;
	localparam logic [2:0] STS_EXISTS    = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_EMPTY     = 3'd4;

	// one stored entry
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name;
		logic [QTY_W-1:0]  qty;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP,
		S_DUMP
	} fsm_state_t;

	// where the RAM write data comes from
	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_NEW,
		WR_UPD
	} wr_sel_t;

	// where a single result takes its entry fields from
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_INPUT,
		RES_RAM,
		RES_UPD
	} res_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic       idx_clr;
		logic       idx_inc;
		logic       idx_dec;
		logic       idx_to_cnt;
		logic       pos_set;
		logic       rd_en;
		logic       rd_prev;
		logic       wr_en;
		wr_sel_t    wr_sel;
		logic       cnt_inc;
		logic       res_set;
		logic [2:0] res_status;
		res_sel_t   res_sel;
		logic       out_load;
		logic       out_dump;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] action;
		logic       cnt_zero;
		logic       cnt_full;
		logic       idx_eq_cnt;
		logic       idx_eq_pos;
		logic       idx_last;
		logic       key_lt;
		logic       key_eq;
		logic       out_free;
	} dp_stat_t;

endpackage

FILE: src/skt_ram.sv
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/skt_ctrl.sv
module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  skt_pkg::dp_stat_t stat,
	output skt_pkg::ctl_cmd_t cmd
);

	skt_pkg::fsm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != skt_pkg::S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			skt_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = skt_pkg::S_DECODE;
				end
			end

			skt_pkg::S_DECODE: begin
				if (stat.action == skt_pkg::ACT_DUMP) begin
					if (stat.cnt_zero) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = skt_pkg::STS_EMPTY;
						cmd.res_sel    = skt_pkg::RES_ZERO;
						state_d        = skt_pkg::S_RESP;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = skt_pkg::S_DUMP;
					end
				end else if (stat.action == skt_pkg::ACT_INSERT && stat.cnt_full) begin
					// full is reported before any duplicate test
					cmd.res_set    = 1'b1;
					cmd.res_status = skt_pkg::STS_FULL;
					cmd.res_sel    = skt_pkg::RES_ZERO;
					state_d        = skt_pkg::S_RESP;
				end else begin
					state_d = skt_pkg::S_SCAN_RD;
				end
			end

			// walk up from slot 0 to the first key not below the input key
			skt_pkg::S_SCAN_RD: begin
				if (stat.idx_eq_cnt) begin
					if (stat.action == skt_pkg::ACT_INSERT) begin
						// append at the end: the shift walk starts and ends here
						cmd.pos_set = 1'b1;
						state_d     = skt_pkg::S_SHIFT_RD;
					end else begin
						cmd.res_set    = 1'b1;
						cmd.res_status = skt_pkg::STS_NOT_FOUND;
						cmd.res_sel    = skt_pkg::RES_ZERO;
						state_d        = skt_pkg::S_RESP;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = skt_pkg::S_SCAN_CMP;
				end
			end

			skt_pkg::S_SCAN_CMP: begin
				if (stat.key_lt) begin
					cmd.idx_inc = 1'b1;
					state_d     = skt_pkg::S_SCAN_RD;
				end else begin
					state_d     = skt_pkg::S_RESP;
					cmd.res_set = 1'b1;
					unique case (stat.action)
						skt_pkg::ACT_INSERT: begin
							if (stat.key_eq) begin
								cmd.res_status = skt_pkg::STS_EXISTS;
								cmd.res_sel    = skt_pkg::RES_ZERO;
							end else begin
								cmd.res_set    = 1'b0;
								cmd.pos_set    = 1'b1;
								cmd.idx_to_cnt = 1'b1;
								state_d        = skt_pkg::S_SHIFT_RD;
							end
						end
						skt_pkg::ACT_UPDATE: begin
							if (stat.key_eq) begin
								cmd.wr_en      = 1'b1;
								cmd.wr_sel     = skt_pkg::WR_UPD;
								cmd.res_status = skt_pkg::STS_OK;
								cmd.res_sel    = skt_pkg::RES_UPD;
							end else begin
								cmd.res_status = skt_pkg::STS_NOT_FOUND;
								cmd.res_sel    = skt_pkg::RES_ZERO;
							end
						end
						default: begin
							// search; dump never reaches the scan
							if (stat.key_eq) begin
								cmd.res_status = skt_pkg::STS_OK;
								cmd.res_sel    = skt_pkg::RES_RAM;
							end else begin
								cmd.res_status = skt_pkg::STS_NOT_FOUND;
								cmd.res_sel    = skt_pkg::RES_ZERO;
							end
						end
					endcase
				end
			end

			// move entries up one slot from the top down to the insert point
			skt_pkg::S_SHIFT_RD: begin
				if (stat.idx_eq_pos) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = skt_pkg::WR_NEW;
					cmd.cnt_inc    = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_status = skt_pkg::STS_OK;
					cmd.res_sel    = skt_pkg::RES_INPUT;
					state_d        = skt_pkg::S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = skt_pkg::S_SHIFT_WR;
				end
			end

			skt_pkg::S_SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = skt_pkg::WR_SHIFT;
				cmd.idx_dec = 1'b1;
				state_d     = skt_pkg::S_SHIFT_RD;
			end

			skt_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = skt_pkg::S_IDLE;
				end
			end

			// RAM data for slot idx is ready; hand it out, then decode reads the next
			skt_pkg::S_DUMP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_dump = 1'b1;
					if (stat.idx_last) begin
						state_d = skt_pkg::S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = skt_pkg::S_DECODE;
					end
				end
			end

			default: begin
				state_d = skt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/skt_dpath.sv
module skt_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skt_pkg::ctl_cmd_t                   cmd,
	output skt_pkg::dp_stat_t                   stat,
	input  logic [1:0]                          action,
	input  logic signed [skt_pkg::KEY_W-1:0]    part_key,
	input  logic [skt_pkg::NAME_W-1:0]          name_word,
	input  logic signed [skt_pkg::QTY_W-1:0]    amount,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic signed [skt_pkg::KEY_W-1:0]    entry_key,
	output logic [skt_pkg::NAME_W-1:0]          entry_name,
	output logic signed [skt_pkg::QTY_W-1:0]    entry_quantity,
	output logic                                last
);

	// latched item
	logic [1:0]                   action_q;
	logic [skt_pkg::KEY_W-1:0]    key_q;
	logic [skt_pkg::NAME_W-1:0]   name_q;
	logic [skt_pkg::QTY_W-1:0]    amt_q;

	// walk index, insert point, fill count
	logic [skt_pkg::CNT_W-1:0]    idx_q;
	logic [skt_pkg::CNT_W-1:0]    pos_q;
	logic [skt_pkg::CNT_W-1:0]    cnt_q;

	// pending single result
	logic [2:0]                   res_status_q;
	skt_pkg::res_sel_t            res_sel_q;

	// RAM side
	skt_pkg::entry_t              rdata;
	skt_pkg::entry_t              wdata;
	logic [skt_pkg::CNT_W-1:0]    raddr_full;
	logic [skt_pkg::QTY_W-1:0]    upd_qty;

	// output register
	logic                         out_valid_q;
	logic [2:0]                   out_status_q;
	skt_pkg::entry_t              out_entry_q;
	logic                         out_last_q;
	logic                         out_free;
	skt_pkg::res_sel_t            out_sel;
	skt_pkg::entry_t              out_entry_d;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= action;
			key_q    <= part_key;
			name_q   <= name_word;
			amt_q    <= amount;
		end
	end

	// index, insert point and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			res_status_q <= skt_pkg::STS_OK;
			res_sel_q    <= skt_pkg::RES_ZERO;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_to_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + skt_pkg::CNT_W'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - skt_pkg::CNT_W'(1);
			end
			if (cmd.pos_set) begin
				pos_q <= idx_q;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + skt_pkg::CNT_W'(1);
			end
			if (cmd.res_set) begin
				res_status_q <= cmd.res_status;
				res_sel_q    <= cmd.res_sel;
			end
		end
	end

	// read at the index, or one below it while shifting
	assign raddr_full = cmd.rd_prev ? (idx_q - skt_pkg::CNT_W'(1)) : idx_q;
	assign upd_qty    = rdata.qty + amt_q;

	always_comb begin
		unique case (cmd.wr_sel)
			skt_pkg::WR_NEW: wdata = '{key: key_q, name: name_q, qty: amt_q};
			skt_pkg::WR_UPD: wdata = '{key: rdata.key, name: rdata.name, qty: upd_qty};
			default:         wdata = rdata;
		endcase
	end

	skt_ram #(
		.WIDTH (skt_pkg::ENTRY_W),
		.DEPTH (skt_pkg::TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[skt_pkg::ADDR_W-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr_full[skt_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	// status to the controller
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		stat.action     = action_q;
		stat.cnt_zero   = (cnt_q == '0);
		stat.cnt_full   = (cnt_q == skt_pkg::CNT_W'(skt_pkg::TABLE_ENTRIES));
		stat.idx_eq_cnt = (idx_q == cnt_q);
		stat.idx_eq_pos = (idx_q == pos_q);
		stat.idx_last   = ((idx_q + skt_pkg::CNT_W'(1)) == cnt_q);
		stat.key_lt     = ($signed(rdata.key) < $signed(key_q));
		stat.key_eq     = (rdata.key == key_q);
		stat.out_free   = out_free;
	end

	// result field selection
	assign out_sel = cmd.out_dump ? skt_pkg::RES_RAM : res_sel_q;

	always_comb begin
		unique case (out_sel)
			skt_pkg::RES_INPUT: out_entry_d = '{key: key_q, name: name_q, qty: amt_q};
			skt_pkg::RES_RAM:   out_entry_d = rdata;
			skt_pkg::RES_UPD:   out_entry_d = '{key: rdata.key, name: rdata.name, qty: upd_qty};
			default:            out_entry_d = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_entry_q  <= out_entry_d;
			out_status_q <= cmd.out_dump ? skt_pkg::STS_OK : res_status_q;
			out_last_q   <= cmd.out_dump ? stat.idx_last : 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign entry_key      = out_entry_q.key;
	assign entry_name     = out_entry_q.name;
	assign entry_quantity = out_entry_q.qty;
	assign last           = out_last_q;

endmodule

FILE: src/sorted_keyed_table_unit.sv
// Channel | Handshake          | Payload
// input   | in_valid/in_stall  | action, part_key, name_word, amount
// output  | out_valid/out_stall| status, entry_key, entry_name, entry_quantity, last
//
// Entries sit in key order in one entry RAM with a registered read. Searches, updates and
// inserts into a non-full table scan it from slot 0 past each entry with a smaller key;
// an insert then moves each larger entry up one slot. A dump reads every entry in order,
// one result each. The input opens again once the last result is loaded for output.
// Output stalls delay that load. arst_n clears the entry count; the RAM is not cleared.
module sorted_keyed_table_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       action,
	input  logic signed [skt_pkg::KEY_W-1:0] part_key,
	input  logic [skt_pkg::NAME_W-1:0]       name_word,
	input  logic signed [skt_pkg::QTY_W-1:0] amount,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic signed [skt_pkg::KEY_W-1:0] entry_key,
	output logic [skt_pkg::NAME_W-1:0]       entry_name,
	output logic signed [skt_pkg::QTY_W-1:0] entry_quantity,
	output logic                             last
);

	skt_pkg::ctl_cmd_t cmd;
	skt_pkg::dp_stat_t stat;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	skt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.part_key       (part_key),
		.name_word      (name_word),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.entry_key      (entry_key),
		.entry_name     (entry_name),
		.entry_quantity (entry_quantity),
		.last           (last)
	);

endmodule

FILE: src/skt_checker.sv
module skt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [2:0]                       status,
	input logic signed [skt_pkg::KEY_W-1:0] entry_key,
	input logic [skt_pkg::NAME_W-1:0]       entry_name,
	input logic signed [skt_pkg::QTY_W-1:0] entry_quantity,
	input logic                             last
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: an accept is followed by a busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken right after an accept");

	// error results carry no entry and close the item
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != skt_pkg::STS_OK |->
			last && entry_key == '0 && entry_name == '0 && entry_quantity == '0)
		else $error("error result malformed");

	// while a dump result other than the final one is offered, the input side is closed
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input opened in the middle of a dump");

endmodule

bind sorted_keyed_table_unit skt_checker u_skt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.entry_key      (entry_key),
	.entry_name     (entry_name),
	.entry_quantity (entry_quantity),
	.last           (last)
);

FILE: bench/tb_sorted_keyed_table_unit.sv
`timescale 1ns / 1ps

module tb_sorted_keyed_table_unit;

	localparam int RANDOM_ITEMS = 260;
	localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// one result item as seen on the output channel
	typedef struct packed {
		logic [2:0]                       status;
		logic signed [skt_pkg::KEY_W-1:0] key;
		logic [skt_pkg::NAME_W-1:0]       name;
		logic signed [skt_pkg::QTY_W-1:0] qty;
		logic                             last;
	} entry_result_t;

	// shadow of the sorted table plus the queue of results still owed
	class table_scoreboard;
		logic signed [skt_pkg::KEY_W-1:0] keys  [skt_pkg::TABLE_ENTRIES];
		logic [skt_pkg::NAME_W-1:0]       names [skt_pkg::TABLE_ENTRIES];
		logic signed [skt_pkg::QTY_W-1:0] qtys  [skt_pkg::TABLE_ENTRIES];
		int                               count;
		entry_result_t                    pending [$];
		int                               errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void push_result(logic [2:0] st, logic signed [skt_pkg::KEY_W-1:0] k,
			logic [skt_pkg::NAME_W-1:0] nm, logic signed [skt_pkg::QTY_W-1:0] q, logic lst);
			entry_result_t r;
			r.status = st;
			r.key    = k;
			r.name   = nm;
			r.qty    = q;
			r.last   = lst;
			pending.push_back(r);
		endfunction

		// first slot whose key is not below k
		function int find_slot(logic signed [skt_pkg::KEY_W-1:0] k);
			int i;
			i = 0;
			while (i < count && keys[i] < k)
				i++;
			return i;
		endfunction

		// apply one accepted command to the shadow table
		function void record_command(logic [1:0] act, logic signed [skt_pkg::KEY_W-1:0] k,
			logic [skt_pkg::NAME_W-1:0] nm, logic signed [skt_pkg::QTY_W-1:0] amt);
			int  pos;
			bit  hit;
			pos = find_slot(k);
			hit = (pos < count) && (keys[pos] == k);
			case (act)
			skt_pkg::ACT_INSERT: begin
				// full wins over duplicate
				if (count >= skt_pkg::TABLE_ENTRIES)
					push_result(skt_pkg::STS_FULL, '0, '0, '0, 1'b1);
				else if (hit)
					push_result(skt_pkg::STS_EXISTS, '0, '0, '0, 1'b1);
				else begin
					for (int i = count; i > pos; i--) begin
						keys[i]  = keys[i-1];
						names[i] = names[i-1];
						qtys[i]  = qtys[i-1];
					end
					keys[pos]  = k;
					names[pos] = nm;
					qtys[pos]  = amt;
					count++;
					push_result(skt_pkg::STS_OK, k, nm, amt, 1'b1);
				end
			end
			skt_pkg::ACT_SEARCH, skt_pkg::ACT_UPDATE: begin
				if (!hit)
					push_result(skt_pkg::STS_NOT_FOUND, '0, '0, '0, 1'b1);
				else begin
					// quantity wraps at 32 bits
					if (act == skt_pkg::ACT_UPDATE)
						qtys[pos] = qtys[pos] + amt;
					push_result(skt_pkg::STS_OK, keys[pos], names[pos], qtys[pos], 1'b1);
				end
			end
			default: begin
				if (count == 0)
					push_result(skt_pkg::STS_EMPTY, '0, '0, '0, 1'b1);
				else
					for (int i = 0; i < count; i++)
						push_result(skt_pkg::STS_OK, keys[i], names[i], qtys[i],
							i == count - 1);
			end
			endcase
		endfunction

		task report(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one delivered result with the oldest one owed
		task check_entry(entry_result_t got);
			entry_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result status=%0d key=%0d", got.status, got.key));
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.key !== want.key)
					report($sformatf("entry_key %0d, want %0d", got.key, want.key));
				if (got.name !== want.name)
					report($sformatf("entry_name %h, want %h", got.name, want.name));
				if (got.qty !== want.qty)
					report($sformatf("entry_quantity %0d, want %0d", got.qty, want.qty));
				if (got.last !== want.last)
					report($sformatf("last %0b, want %0b (key %0d)", got.last, want.last,
						want.key));
			end
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [1:0]                       action;
	logic signed [skt_pkg::KEY_W-1:0] part_key;
	logic [skt_pkg::NAME_W-1:0]       name_word;
	logic signed [skt_pkg::QTY_W-1:0] amount;
	logic                             out_valid;
	logic                             out_stall;
	logic [2:0]                       status;
	logic signed [skt_pkg::KEY_W-1:0] entry_key;
	logic [skt_pkg::NAME_W-1:0]       entry_name;
	logic signed [skt_pkg::QTY_W-1:0] entry_quantity;
	logic                             last;

	table_scoreboard sb;
	logic signed [skt_pkg::KEY_W-1:0] used_keys [$];
	bit tx_calm;
	bit rx_calm;
	int rx_hold;
	int rx_seen;

	sorted_keyed_table_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.part_key       (part_key),
		.name_word      (name_word),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.entry_key      (entry_key),
		.entry_name     (entry_name),
		.entry_quantity (entry_quantity),
		.last           (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.record_command(action, part_key, name_word, amount);
			if (out_valid && !out_stall) begin
				sb.check_entry({status, entry_key, entry_name, entry_quantity, last});
				rx_seen++;
				if (rx_seen % 40 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
			end
		end
	end

	// receiver holds off for the drawn number of cycles after each item
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// key not drawn from earlier inserts: near zero, extremes, or anywhere
	function automatic logic signed [skt_pkg::KEY_W-1:0] fresh_key();
		case ($urandom_range(0, 3))
		0: return $urandom_range(0, 200) - 100;
		1: return $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 2)
			: KEY_MAX - $urandom_range(0, 2);
		default: return $urandom;
		endcase
	endfunction

	// present one item after a random gap and hold it until taken
	task automatic send_item(input logic [1:0] act,
		input logic signed [skt_pkg::KEY_W-1:0] k, input logic [skt_pkg::NAME_W-1:0] nm,
		input logic signed [skt_pkg::QTY_W-1:0] amt);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		action    <= act;
		part_key  <= k;
		name_word <= nm;
		amount    <= amt;
		do
			@(posedge clk);
		while (in_stall);
		if (act == skt_pkg::ACT_INSERT)
			used_keys.push_back(k);
	endtask

	// stop sending until every owed result is back
	task drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int                               pick;
		logic [1:0]                       act;
		logic signed [skt_pkg::KEY_W-1:0] k;
		logic signed [skt_pkg::QTY_W-1:0] amt;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = skt_pkg::ACT_INSERT;
		part_key  = '0;
		name_word = '0;
		amount    = '0;
		out_stall = 1'b0;
		rx_hold   = 0;
		rx_seen   = 0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// empty table: dump, search and update misses
		send_item(skt_pkg::ACT_DUMP, 0, '0, 0);
		send_item(skt_pkg::ACT_SEARCH, 0, '1, 0);
		send_item(skt_pkg::ACT_UPDATE, 5, '0, 7);
		// key and field extremes
		send_item(skt_pkg::ACT_INSERT, KEY_MIN, '1, KEY_MAX);
		send_item(skt_pkg::ACT_INSERT, KEY_MAX, '0, KEY_MIN);
		send_item(skt_pkg::ACT_INSERT, 0, 64'h0123_4567_89AB_CDEF, -1);
		send_item(skt_pkg::ACT_INSERT, -1, {$urandom, $urandom}, 0);
		send_item(skt_pkg::ACT_INSERT, 0, '1, 99);
		send_item(skt_pkg::ACT_SEARCH, KEY_MIN, '0, 0);
		send_item(skt_pkg::ACT_SEARCH, KEY_MAX, '1, -5);
		// quantity wraps both ways
		send_item(skt_pkg::ACT_UPDATE, KEY_MAX, '0, -1);
		send_item(skt_pkg::ACT_UPDATE, KEY_MIN, '0, 1);
		send_item(skt_pkg::ACT_SEARCH, 12345, '0, 0);
		send_item(skt_pkg::ACT_UPDATE, 0, '0, 0);
		send_item(skt_pkg::ACT_DUMP, KEY_MAX, '1, KEY_MIN);
		send_item(skt_pkg::ACT_INSERT, 1, {$urandom, $urandom}, $urandom);
		send_item(skt_pkg::ACT_DUMP, 0, '0, 0);

		// random mix, heavy on inserts so the table fills up
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 25 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain();
			pick = $urandom_range(0, 99);
			act  = (pick < 50) ? skt_pkg::ACT_INSERT : (pick < 68) ? skt_pkg::ACT_SEARCH
				: (pick < 90) ? skt_pkg::ACT_UPDATE : skt_pkg::ACT_DUMP;
			if (used_keys.size() == 0)
				k = fresh_key();
			else if ($urandom_range(0, 9) < ((act == skt_pkg::ACT_INSERT) ? 3 : 8))
				k = used_keys[$urandom_range(0, used_keys.size() - 1)];
			else
				k = fresh_key();
			amt = $urandom;
			if ($urandom_range(0, 7) == 0)
				amt = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
			send_item(act, k, {$urandom, $urandom}, amt);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
